### rtl/jmsf_pkg.sv
// ----------------------------------------------------------------------------
// jmsf_pkg
// Types and constants shared by the JPEG marker segment filter modules.
// ----------------------------------------------------------------------------
package jmsf_pkg;

  localparam logic [7:0]  BYTE_FF    = 8'hFF;
  localparam logic [7:0]  MARK_SOI   = 8'hD8;
  localparam logic [7:0]  MARK_SOS   = 8'hDA;
  localparam logic [3:0]  MARK_SOF_HI = 4'hC;
  localparam logic [15:0] MASK_RESET = 16'hFECC;

  typedef enum logic [2:0] {
    PH_START1 = 3'd0,
    PH_START2 = 3'd1,
    PH_SEGFF  = 3'd2,
    PH_MARKER = 3'd3,
    PH_LENHI  = 3'd4,
    PH_LENLO  = 3'd5,
    PH_SKIP   = 3'd6
  } phase_t;

  typedef enum logic [2:0] {
    R_SCAN_START = 3'd0,
    R_BAD_START  = 3'd1,
    R_MISSING_FF = 3'd2,
    R_FORBIDDEN  = 3'd3,
    R_ENDED      = 3'd4
  } reason_t;

  typedef struct packed {
    phase_t      phase;
    logic [7:0]  marker_code;
    logic [7:0]  length_high;
    logic [15:0] segment_remaining;
    logic        decided;
  } parse_state_t;

  typedef struct packed {
    logic    valid;
    logic    verdict;
    reason_t reason;
  } result_t;

  localparam parse_state_t STATE_RESET = '{
    phase:             PH_START1,
    marker_code:       8'h00,
    length_high:       8'h00,
    segment_remaining: 16'h0000,
    decided:           1'b0
  };

endpackage

### rtl/jmsf_parse.sv
// ----------------------------------------------------------------------------
// jmsf_parse
// Next-state and verdict logic for one byte of the marker segment parser.
// ----------------------------------------------------------------------------
module jmsf_parse (
  input  jmsf_pkg::parse_state_t cur,
  input  logic [7:0]             data_byte,
  input  logic                   end_of_file,
  input  logic [15:0]            forbidden_mask,
  output jmsf_pkg::parse_state_t nxt,
  output jmsf_pkg::result_t      res
);

  logic [15:0] seg_len;
  logic [15:0] seg_rem;
  logic [15:0] rem_dec;
  logic        is_forbidden;

  assign seg_len      = {cur.length_high, data_byte};
  assign seg_rem      = (seg_len >= 16'd2) ? (seg_len - 16'd2) : 16'd0;
  assign rem_dec      = (cur.segment_remaining != 16'd0) ?
                        (cur.segment_remaining - 16'd1) : 16'd0;
  assign is_forbidden = (cur.marker_code[7:4] == jmsf_pkg::MARK_SOF_HI) &&
                        forbidden_mask[cur.marker_code[3:0]];

  always_comb begin
    nxt         = cur;
    res.valid   = 1'b0;
    res.verdict = 1'b1;
    res.reason  = jmsf_pkg::R_ENDED;
    if (!cur.decided) begin
      case (cur.phase)
        jmsf_pkg::PH_START2: begin
          if (data_byte != jmsf_pkg::MARK_SOI) begin
            res.valid  = 1'b1;
            res.reason = jmsf_pkg::R_BAD_START;
          end else begin
            nxt.phase = jmsf_pkg::PH_SEGFF;
          end
        end
        jmsf_pkg::PH_SEGFF: begin
          if (data_byte != jmsf_pkg::BYTE_FF) begin
            res.valid  = 1'b1;
            res.reason = jmsf_pkg::R_MISSING_FF;
          end else begin
            nxt.phase = jmsf_pkg::PH_MARKER;
          end
        end
        jmsf_pkg::PH_MARKER: begin
          nxt.marker_code = data_byte;
          nxt.phase       = jmsf_pkg::PH_LENHI;
        end
        jmsf_pkg::PH_LENHI: begin
          nxt.length_high = data_byte;
          nxt.phase       = jmsf_pkg::PH_LENLO;
        end
        jmsf_pkg::PH_LENLO: begin
          if (is_forbidden) begin
            res.valid  = 1'b1;
            res.reason = jmsf_pkg::R_FORBIDDEN;
          end else begin
            nxt.segment_remaining = seg_rem;
            if (seg_rem == 16'd0) begin
              if (cur.marker_code == jmsf_pkg::MARK_SOS) begin
                res.valid   = 1'b1;
                res.verdict = 1'b0;
                res.reason  = jmsf_pkg::R_SCAN_START;
              end else begin
                nxt.phase = jmsf_pkg::PH_SEGFF;
              end
            end else begin
              nxt.phase = jmsf_pkg::PH_SKIP;
            end
          end
        end
        jmsf_pkg::PH_SKIP: begin
          nxt.segment_remaining = rem_dec;
          if (rem_dec == 16'd0) begin
            if (cur.marker_code == jmsf_pkg::MARK_SOS) begin
              res.valid   = 1'b1;
              res.verdict = 1'b0;
              res.reason  = jmsf_pkg::R_SCAN_START;
            end else begin
              nxt.phase = jmsf_pkg::PH_SEGFF;
            end
          end
        end
        default: begin
          if (data_byte != jmsf_pkg::BYTE_FF) begin
            res.valid  = 1'b1;
            res.reason = jmsf_pkg::R_BAD_START;
          end else begin
            nxt.phase = jmsf_pkg::PH_START2;
          end
        end
      endcase
      // undecided at the last byte of the file
      if (!res.valid && end_of_file) begin
        res.valid   = 1'b1;
        res.verdict = 1'b1;
        res.reason  = jmsf_pkg::R_ENDED;
      end
      if (res.valid) begin
        nxt.decided = 1'b1;
      end
    end
    if (end_of_file) begin
      nxt = jmsf_pkg::STATE_RESET;
    end
  end

endmodule

### rtl/jpeg_marker_segment_filter.sv
// ----------------------------------------------------------------------------
// jpeg_marker_segment_filter
// Byte-serial JPEG marker segment checker giving one verdict per file.
// ----------------------------------------------------------------------------
// Bytes of a file enter on the in_ channel (in_data_byte, in_end_of_file on
// the last byte). Each file yields exactly one item on the out_ channel:
// out_verdict 0 accept, 1 drop, with out_reason. Bytes after the verdict are
// swallowed until the end-of-file byte, which rearms the parser.
// An accepted byte is registered in the input register and parsed from there;
// any verdict it causes is registered in the output register as the parse
// stage advances. Without a stall one byte per cycle is taken sustained; the
// input register and the output register form a two-stage pipeline, so a
// byte is accepted while a verdict waits. When the receiver stalls the
// parse stage holds, and in_ready drops once the input register is full.
// The cfg_ channel writes the forbidden marker mask (bit n forbids marker
// C0+n); cfg_ready is always high. Synchronous reset clears the pipeline,
// rearms the parser and loads the mask with FECC.
// ----------------------------------------------------------------------------
module jpeg_marker_segment_filter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_end_of_file,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_verdict,
  output logic [2:0]  out_reason,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_forbidden_mask
);

  logic                   s1_valid_r, s1_valid_nxt;
  logic [7:0]             s1_byte_r;
  logic                   s1_eof_r;
  logic [15:0]            mask_r;
  jmsf_pkg::parse_state_t st_r, st_nxt;
  jmsf_pkg::result_t      res;
  logic                   out_valid_r, out_valid_nxt;
  logic                   out_verdict_r;
  jmsf_pkg::reason_t      out_reason_r;
  logic                   adv;

  jmsf_parse u_parse (
    .cur            (st_r),
    .data_byte      (s1_byte_r),
    .end_of_file    (s1_eof_r),
    .forbidden_mask (mask_r),
    .nxt            (st_nxt),
    .res            (res)
  );

  // parse stage moves when the result register is free or being emptied
  assign adv       = !out_valid_r || out_ready;
  assign in_ready  = !s1_valid_r || adv;
  assign cfg_ready = 1'b1;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_ready) begin
      s1_valid_nxt = in_valid;
    end
    out_valid_nxt = out_valid_r;
    if (adv) begin
      out_valid_nxt = s1_valid_r && res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= jmsf_pkg::STATE_RESET;
      mask_r      <= jmsf_pkg::MASK_RESET;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (adv && s1_valid_r) begin
        st_r <= st_nxt;
      end
      if (cfg_valid && cfg_ready) begin
        mask_r <= cfg_forbidden_mask;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_byte_r <= in_data_byte;
      s1_eof_r  <= in_end_of_file;
    end
    if (adv && s1_valid_r && res.valid) begin
      out_verdict_r <= res.verdict;
      out_reason_r  <= res.reason;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_verdict = out_verdict_r;
  assign out_reason  = out_reason_r;

  a_eof_rearms: assert property (@(posedge clk) disable iff (!rst_n)
    adv && s1_valid_r && s1_eof_r |=>
      !st_r.decided && st_r.phase == jmsf_pkg::PH_START1)
    else $error("end of file did not rearm the parser");

  a_decided_silent: assert property (@(posedge clk) disable iff (!rst_n)
    adv && st_r.decided |=> !out_valid_r)
    else $error("verdict produced after file already decided");

  a_accept_reason: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_verdict_r == 1'b0) == (out_reason_r == jmsf_pkg::R_SCAN_START)))
    else $error("verdict and reason disagree");

  a_remaining_in_skip: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.segment_remaining != 16'd0 |-> st_r.phase == jmsf_pkg::PH_SKIP)
    else $error("payload count left outside skip phase");

endmodule

### bench/jpeg_marker_segment_filter_tb.sv
// ----------------------------------------------------------------------------
// jpeg_marker_segment_filter_tb
// Self-checking bench for the JPEG marker segment filter.
// ----------------------------------------------------------------------------
// Whole image files are streamed in byte by byte with random gaps on the
// input side and random stalls on the verdict side. A parser written in the
// bench follows every accepted byte and queues the verdict each file should
// get. Every verdict leaving the block is checked against the oldest queued
// one. Directed files cover each verdict reason. Several forbidden-marker
// masks are then tried, and one segment has a long payload. The random part
// mixes well-formed files with random content, corrupted and cut-short
// files, and byte noise, and rewrites the mask between groups of files.
// ----------------------------------------------------------------------------
module jpeg_marker_segment_filter_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic       VERDICT_ACCEPT = 1'b0;
  localparam logic       VERDICT_DROP   = 1'b1;
  localparam logic [3:0] MARK_APP_HI    = 4'hE;
  localparam logic [7:0] MARK_DQT       = 8'hDB;
  localparam int         MAX_WAIT       = 17;
  localparam int         DRAIN_CYCLES   = 4;
  localparam int         STALL_LIMIT    = 2000;
  localparam int         RANDOM_BYTES   = 560;

  typedef struct {
    logic              verdict;
    jmsf_pkg::reason_t reason;
  } verdict_item_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = '0;
  logic        in_end_of_file = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_verdict;
  logic [2:0]  out_reason;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_forbidden_mask = '0;

  jpeg_marker_segment_filter uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_data_byte       (in_data_byte),
    .in_end_of_file     (in_end_of_file),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_verdict        (out_verdict),
    .out_reason         (out_reason),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_forbidden_mask (cfg_forbidden_mask)
  );

  // parser state kept by the bench
  jmsf_pkg::phase_t p_phase;
  logic [7:0]       p_marker;
  logic [7:0]       p_len_hi;
  logic [15:0]      p_remain;
  logic             p_done;
  logic [15:0]      p_mask;

  verdict_item_t verdicts_due[$];
  logic [7:0]    img[$];

  bit in_idle_on  = 1'b1;
  bit out_idle_on = 1'b1;
  int out_hold    = 0;
  int idle_cycles = 0;

  int fault_count    = 0;
  int files_sent     = 0;
  int sent_bytes     = 0;
  int parsed_bytes   = 0;
  int accepted_files = 0;
  int dropped_files  = 0;
  int mask_writes    = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int draw_wait(bit on);
    return on ? $urandom_range(0, MAX_WAIT) : 0;
  endfunction

  // ------------------------------------------------------------ parser model
  task automatic rearm_parser();
    p_phase  = jmsf_pkg::PH_START1;
    p_marker = '0;
    p_len_hi = '0;
    p_remain = '0;
    p_done   = 1'b0;
  endtask

  task automatic give_verdict(input logic v, input jmsf_pkg::reason_t r);
    verdict_item_t item;
    item.verdict = v;
    item.reason  = r;
    verdicts_due.push_back(item);
    p_done = 1'b1;
  endtask

  task automatic close_segment();
    if (p_marker == jmsf_pkg::MARK_SOS) give_verdict(VERDICT_ACCEPT, jmsf_pkg::R_SCAN_START);
    else p_phase = jmsf_pkg::PH_SEGFF;
  endtask

  task automatic judge_byte(input logic [7:0] b, input logic eof);
    logic [15:0] seg_len;
    if (!p_done) begin
      parsed_bytes++;
      case (p_phase)
        jmsf_pkg::PH_START2: begin
          if (b != jmsf_pkg::MARK_SOI) give_verdict(VERDICT_DROP, jmsf_pkg::R_BAD_START);
          else p_phase = jmsf_pkg::PH_SEGFF;
        end
        jmsf_pkg::PH_SEGFF: begin
          if (b != jmsf_pkg::BYTE_FF) give_verdict(VERDICT_DROP, jmsf_pkg::R_MISSING_FF);
          else p_phase = jmsf_pkg::PH_MARKER;
        end
        jmsf_pkg::PH_MARKER: begin
          p_marker = b;
          p_phase  = jmsf_pkg::PH_LENHI;
        end
        jmsf_pkg::PH_LENHI: begin
          p_len_hi = b;
          p_phase  = jmsf_pkg::PH_LENLO;
        end
        jmsf_pkg::PH_LENLO: begin
          seg_len = {p_len_hi, b};
          if (p_marker[7:4] == jmsf_pkg::MARK_SOF_HI && p_mask[p_marker[3:0]]) begin
            give_verdict(VERDICT_DROP, jmsf_pkg::R_FORBIDDEN);
          end else begin
            p_remain = (seg_len >= 16'd2) ? seg_len - 16'd2 : 16'd0;
            if (p_remain == 16'd0) close_segment();
            else p_phase = jmsf_pkg::PH_SKIP;
          end
        end
        jmsf_pkg::PH_SKIP: begin
          if (p_remain != 16'd0) p_remain--;
          if (p_remain == 16'd0) close_segment();
        end
        default: begin
          if (b != jmsf_pkg::BYTE_FF) give_verdict(VERDICT_DROP, jmsf_pkg::R_BAD_START);
          else p_phase = jmsf_pkg::PH_START2;
        end
      endcase
      if (!p_done && eof) give_verdict(VERDICT_DROP, jmsf_pkg::R_ENDED);
    end
    if (eof) rearm_parser();
  endtask

  // ------------------------------------------------------------ drivers
  task automatic feed_byte(input logic [7:0] b, input logic eof);
    int gap;
    gap = draw_wait(in_idle_on);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_data_byte   <= b;
    in_end_of_file <= eof;
    do @(posedge clk); while (!in_ready);
    sent_bytes++;
    judge_byte(b, eof);
  endtask

  task automatic send_image();
    for (int i = 0; i < img.size(); i++) feed_byte(img[i], i == img.size() - 1);
    files_sent++;
  endtask

  // lower valid, wait for every verdict, then let the pipeline empty
  task automatic settle_block();
    @(negedge clk);
    in_valid <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic load_mask(input logic [15:0] m);
    @(negedge clk);
    cfg_valid          <= 1'b1;
    cfg_forbidden_mask <= m;
    do @(posedge clk); while (!cfg_ready);
    p_mask = m;
    mask_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // ------------------------------------------------------------ file builders
  function automatic logic [7:0] pick_marker();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return {jmsf_pkg::MARK_SOF_HI, 4'($urandom)};
      5, 6:          return {MARK_APP_HI, 4'($urandom)};
      7:             return 8'($urandom);
      default:       return MARK_DQT;
    endcase
  endfunction

  task automatic add_segment(input logic [7:0] mk, input int body);
    logic [15:0] len_field;
    if ($urandom_range(0, 9) == 0) begin
      len_field = 16'($urandom_range(0, 1));
      body      = 0;
    end else begin
      len_field = 16'(body + 2);
    end
    img.push_back(jmsf_pkg::BYTE_FF);
    img.push_back(mk);
    img.push_back(len_field[15:8]);
    img.push_back(len_field[7:0]);
    repeat (body) img.push_back(8'($urandom));
  endtask

  task automatic compose_image();
    img.delete();
    img.push_back(jmsf_pkg::BYTE_FF);
    img.push_back(jmsf_pkg::MARK_SOI);
    repeat ($urandom_range(0, 3)) add_segment(pick_marker(), $urandom_range(0, 6));
    add_segment(jmsf_pkg::MARK_SOS, $urandom_range(0, 6));
    repeat ($urandom_range(0, 3)) img.push_back(8'($urandom));
  endtask

  // ------------------------------------------------------------ tests
  task automatic test_directed_files();
    img = '{8'h00, jmsf_pkg::BYTE_FF};
    send_image();
    img = '{jmsf_pkg::BYTE_FF, 8'h00};
    send_image();
    img = '{jmsf_pkg::BYTE_FF, jmsf_pkg::MARK_SOI, 8'h7F};
    send_image();
    img = '{jmsf_pkg::BYTE_FF, jmsf_pkg::MARK_SOI, jmsf_pkg::BYTE_FF, jmsf_pkg::MARK_SOS,
            8'h00, 8'h00};
    send_image();
    img = '{jmsf_pkg::BYTE_FF, jmsf_pkg::MARK_SOI, jmsf_pkg::BYTE_FF,
            {jmsf_pkg::MARK_SOF_HI, 4'h2}, 8'h00, 8'h02, jmsf_pkg::BYTE_FF};
    send_image();
    img = '{jmsf_pkg::BYTE_FF};
    send_image();
    settle_block();
  endtask

  task automatic test_mask_settings();
    logic [15:0] masks[5];
    logic [7:0]  mk;
    masks = '{16'h0000, 16'hFFFF, 16'h0001, 16'h8000, 16'($urandom)};
    foreach (masks[m]) begin
      load_mask(masks[m]);
      for (int k = 0; k < 4; k++) begin
        case (k)
          0:       mk = {jmsf_pkg::MARK_SOF_HI, 4'h0};
          1:       mk = {jmsf_pkg::MARK_SOF_HI, 4'hF};
          default: mk = {jmsf_pkg::MARK_SOF_HI, 4'($urandom)};
        endcase
        img = '{jmsf_pkg::BYTE_FF, jmsf_pkg::MARK_SOI, jmsf_pkg::BYTE_FF, mk, 8'h00, 8'h02,
                jmsf_pkg::BYTE_FF, jmsf_pkg::MARK_SOS, 8'h00, 8'h02};
        send_image();
      end
      settle_block();
    end
  endtask

  task automatic test_long_segment();
    load_mask(16'h0000);
    in_idle_on  = 1'b0;
    out_idle_on = 1'b0;
    img.delete();
    img.push_back(jmsf_pkg::BYTE_FF);
    img.push_back(jmsf_pkg::MARK_SOI);
    img.push_back(jmsf_pkg::BYTE_FF);
    img.push_back({jmsf_pkg::MARK_SOF_HI, 4'h1});
    img.push_back(8'h01);
    img.push_back(8'h03);
    repeat (257) img.push_back(8'($urandom));
    img.push_back(jmsf_pkg::BYTE_FF);
    img.push_back(jmsf_pkg::MARK_SOS);
    img.push_back(8'h00);
    img.push_back(8'h02);
    send_image();
    settle_block();
    in_idle_on  = 1'b1;
    out_idle_on = 1'b1;
  endtask

  task automatic test_random_files();
    int start_bytes;
    int files_here;
    int pick;
    int cut;
    start_bytes = sent_bytes;
    files_here  = 0;
    while (sent_bytes - start_bytes < RANDOM_BYTES) begin
      if (files_here % 12 == 11) begin
        settle_block();
        case ($urandom_range(0, 3))
          0:       load_mask(16'h0000);
          1:       load_mask(16'hFFFF);
          2:       load_mask(jmsf_pkg::MASK_RESET);
          default: load_mask(16'($urandom));
        endcase
      end
      if ($urandom_range(0, 7) == 0) in_idle_on = ($urandom_range(0, 2) != 0);
      if ($urandom_range(0, 7) == 0) out_idle_on = ($urandom_range(0, 2) != 0);
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        compose_image();
        if ($urandom_range(0, 9) == 0) begin
          cut = $urandom_range(1, img.size());
          while (img.size() > cut) void'(img.pop_back());
        end
      end else if (pick < 80) begin
        compose_image();
        img[$urandom_range(0, img.size() - 1)] = 8'($urandom);
      end else if (pick < 88) begin
        // segment with a full-range length, cut short
        img = '{jmsf_pkg::BYTE_FF, jmsf_pkg::MARK_SOI, jmsf_pkg::BYTE_FF, pick_marker(),
                8'($urandom), 8'($urandom)};
        repeat ($urandom_range(0, 5)) img.push_back(8'($urandom));
      end else begin
        img.delete();
        repeat ($urandom_range(1, 8)) img.push_back(8'($urandom));
        if ($urandom_range(0, 1)) img[0] = jmsf_pkg::BYTE_FF;
        if (img.size() > 1 && $urandom_range(0, 1)) img[1] = jmsf_pkg::MARK_SOI;
      end
      send_image();
      files_here++;
    end
    settle_block();
  endtask

  // ------------------------------------------------------------ verdict side
  always @(negedge clk) begin
    if (out_hold > 0) begin
      out_ready <= 1'b0;
      out_hold--;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic report_fault(input string expected_txt);
    fault_count++;
    if (fault_count <= 10)
      $display("%0t: verdict mismatch, expected %s, got verdict %0d reason %0d",
               $realtime, expected_txt, out_verdict, out_reason);
  endtask

  always @(posedge clk) begin
    verdict_item_t due;
    if (rst_n && out_valid && out_ready) begin
      out_hold = draw_wait(out_idle_on);
      if (verdicts_due.size() == 0) begin
        report_fault("no verdict");
      end else begin
        due = verdicts_due.pop_front();
        if (out_verdict !== due.verdict || out_reason !== due.reason)
          report_fault($sformatf("verdict %0d reason %0d", due.verdict, due.reason));
        if (due.verdict == VERDICT_ACCEPT) accepted_files++;
        else dropped_files++;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout after %0d cycles without any handshake", STALL_LIMIT);
      $display("Regression FAIL");
      $finish;
    end
  end

  // ------------------------------------------------------------ sequence
  initial begin
    p_mask = jmsf_pkg::MASK_RESET;
    rearm_parser();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_files();
    test_mask_settings();
    test_long_segment();
    test_random_files();

    $display("covered %0d files, %0d bytes sent, %0d parsed bytes, %0d mask writes",
             files_sent, sent_bytes, parsed_bytes, mask_writes);
    $display("verdicts checked: %0d accepted, %0d dropped, %0d faults",
             accepted_files, dropped_files, fault_count);
    if (fault_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
